// ===== rtl/gcg_pkg.sv =====
// ----------------------------------------------------------------------------
// gcg_pkg
// Shared widths, register codes, configuration record and length helpers
// for the gold code generator.
// ----------------------------------------------------------------------------
package gcg_pkg;

  localparam int MAX_LENGTH = 16;
  localparam int MIN_LENGTH = 2;
  localparam int REG_W      = MAX_LENGTH;
  localparam int LEN_W      = 5;
  localparam int SEL_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [REG_W-1:0] lfsr_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [SEL_W-1:0] sel_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_LENGTH = 3'd0,
    CFG_TAPS_A     = 3'd1,
    CFG_TAPS_B     = 3'd2,
    CFG_INIT_A     = 3'd3,
    CFG_INIT_B     = 3'd4,
    CFG_SELECT_A   = 3'd5,
    CFG_SELECT_B   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    len_t  seq_length;
    lfsr_t taps_a;
    lfsr_t taps_b;
    lfsr_t init_a;
    lfsr_t init_b;
    sel_t  select_a;
    sel_t  select_b;
  } cfg_t;

  localparam len_t  RST_SEQ_LENGTH = 5'd10;
  localparam lfsr_t RST_TAPS       = 16'd1020;
  localparam lfsr_t RST_INIT       = 16'd1023;
  localparam sel_t  RST_SELECT     = 4'd0;

  // clamp the programmed length into the supported range
  function automatic len_t eff_len(input len_t l);
    len_t r;
    r = l;
    if (l < len_t'(MIN_LENGTH)) r = len_t'(MIN_LENGTH);
    if (l > len_t'(MAX_LENGTH)) r = len_t'(MAX_LENGTH);
    return r;
  endfunction

  // ones in the low l stages
  function automatic lfsr_t len_mask(input len_t l);
    return {REG_W{1'b1}} >> (len_t'(REG_W) - l);
  endfunction

endpackage

// ===== rtl/gold_code_generator.sv =====
// ----------------------------------------------------------------------------
// gold_code_generator
// Two-register gold code chip generator with programmable length, taps,
// initial vectors and output stage selects.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready, restart): one transfer per chip tick;
//   restart=1 reloads both registers and the chip counter before the tick.
//   output channel (out_valid/out_ready): one result per input transfer,
//   code_bit, chip_index and period_end, in input order.
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   a write to registers 0..6 updates the register and reloads the shift
//   registers in the next cycle (input held off for the reload), index 7
//   is ignored. write only while the block is idle.
// result: registered, it appears in the cycle after its input transfer.
// throughput: one chip per cycle unless stalled or reloading; the shift,
//   parity and period compare all fit between the state and output registers.
// reset: configuration returns to its defaults and the shift registers are
//   loaded from the default initial vectors in the first cycle after reset,
//   during which in_ready is low.
// stall: the output register holds its result while out_ready is low; a new
//   input is taken in the same cycle the old result leaves.
// ----------------------------------------------------------------------------
module gold_code_generator (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           code_bit,
  output logic [15:0]                    chip_index,
  output logic                           period_end,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcg_pkg::CFG_DATA_W-1:0] cfg_data
);

  gcg_pkg::cfg_t  cfg;
  logic           cfg_write;

  // generator state
  gcg_pkg::lfsr_t shift_reg_a;
  gcg_pkg::lfsr_t shift_reg_b;
  gcg_pkg::lfsr_t chip_counter;
  logic           reload_pending;

  gcg_pkg::len_t  len;
  gcg_pkg::lfsr_t mask;
  gcg_pkg::lfsr_t last;
  gcg_pkg::lfsr_t cnt_cur;
  logic           hit_end;
  logic           accept;

  logic           chip_a;
  logic           chip_b;
  gcg_pkg::lfsr_t adv_a;
  gcg_pkg::lfsr_t adv_b;
  gcg_pkg::lfsr_t load_a;
  gcg_pkg::lfsr_t load_b;

  gcg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_write (cfg_write)
  );

  assign cfg_ready = 1'b1;

  // effective length and period end
  assign len  = gcg_pkg::eff_len(cfg.seq_length);
  assign mask = gcg_pkg::len_mask(len);
  assign last = mask - gcg_pkg::lfsr_t'(1);

  gcg_lfsr u_lfsr_a (
    .state   (shift_reg_a),
    .taps    (cfg.taps_a),
    .init    (cfg.init_a),
    .sel     (cfg.select_a),
    .len     (len),
    .mask    (mask),
    .restart (restart),
    .chip    (chip_a),
    .adv     (adv_a),
    .load    (load_a)
  );

  gcg_lfsr u_lfsr_b (
    .state   (shift_reg_b),
    .taps    (cfg.taps_b),
    .init    (cfg.init_b),
    .sel     (cfg.select_b),
    .len     (len),
    .mask    (mask),
    .restart (restart),
    .chip    (chip_b),
    .adv     (adv_b),
    .load    (load_b)
  );

  // restart clears the count before this chip
  assign cnt_cur = restart ? '0 : chip_counter;
  assign hit_end = cnt_cur >= last;

  // output register frees up in the same cycle it is drained
  assign in_ready = !reload_pending && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_pending <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        reload_pending <= 1'b1;
      end else if (reload_pending) begin
        reload_pending <= 1'b0;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // shift registers and chip counter
  always_ff @(posedge clk) begin
    if (reload_pending) begin
      shift_reg_a  <= load_a;
      shift_reg_b  <= load_b;
      chip_counter <= '0;
    end else if (accept) begin
      if (hit_end) begin
        shift_reg_a  <= load_a;
        shift_reg_b  <= load_b;
        chip_counter <= '0;
      end else begin
        shift_reg_a  <= adv_a;
        shift_reg_b  <= adv_b;
        chip_counter <= cnt_cur + gcg_pkg::lfsr_t'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      code_bit   <= chip_a ^ chip_b;
      chip_index <= cnt_cur;
      period_end <= hit_end;
    end
  end

endmodule

// ===== rtl/gcg_cfg.sv =====
// ----------------------------------------------------------------------------
// gcg_cfg
// Configuration register file; flags every write to a defined register.
// ----------------------------------------------------------------------------
module gcg_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [gcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcg_pkg::CFG_DATA_W-1:0] cfg_data,
  output gcg_pkg::cfg_t                  cfg,
  output logic                           cfg_write
);

  gcg_pkg::cfg_t cfg_next;
  logic          hit;

  always_comb begin
    cfg_next = cfg;
    hit      = 1'b1;
    case (gcg_pkg::cfg_idx_t'(cfg_index))
      gcg_pkg::CFG_SEQ_LENGTH: cfg_next.seq_length = cfg_data[gcg_pkg::LEN_W-1:0];
      gcg_pkg::CFG_TAPS_A:     cfg_next.taps_a     = cfg_data[gcg_pkg::REG_W-1:0];
      gcg_pkg::CFG_TAPS_B:     cfg_next.taps_b     = cfg_data[gcg_pkg::REG_W-1:0];
      gcg_pkg::CFG_INIT_A:     cfg_next.init_a     = cfg_data[gcg_pkg::REG_W-1:0];
      gcg_pkg::CFG_INIT_B:     cfg_next.init_b     = cfg_data[gcg_pkg::REG_W-1:0];
      gcg_pkg::CFG_SELECT_A:   cfg_next.select_a   = cfg_data[gcg_pkg::SEL_W-1:0];
      gcg_pkg::CFG_SELECT_B:   cfg_next.select_b   = cfg_data[gcg_pkg::SEL_W-1:0];
      default:                 hit = 1'b0;
    endcase
  end

  assign cfg_write = cfg_valid && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seq_length <= gcg_pkg::RST_SEQ_LENGTH;
      cfg.taps_a     <= gcg_pkg::RST_TAPS;
      cfg.taps_b     <= gcg_pkg::RST_TAPS;
      cfg.init_a     <= gcg_pkg::RST_INIT;
      cfg.init_b     <= gcg_pkg::RST_INIT;
      cfg.select_a   <= gcg_pkg::RST_SELECT;
      cfg.select_b   <= gcg_pkg::RST_SELECT;
    end else if (cfg_write) begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== rtl/gcg_lfsr.sv =====
// ----------------------------------------------------------------------------
// gcg_lfsr
// One shift register step: restart load, selected stage and feedback shift.
// ----------------------------------------------------------------------------
module gcg_lfsr (
  input  gcg_pkg::lfsr_t state,
  input  gcg_pkg::lfsr_t taps,
  input  gcg_pkg::lfsr_t init,
  input  gcg_pkg::sel_t  sel,
  input  gcg_pkg::len_t  len,
  input  gcg_pkg::lfsr_t mask,
  input  logic           restart,
  output logic           chip,
  output gcg_pkg::lfsr_t adv,
  output gcg_pkg::lfsr_t load
);

  gcg_pkg::lfsr_t cur;
  gcg_pkg::lfsr_t fb_mask;
  logic           fb;

  assign load = init & mask;
  assign cur  = restart ? load : state;

  // last stage always feeds back, taps only below it
  assign fb_mask = (taps & (mask >> 1)) | (mask ^ (mask >> 1));
  assign fb      = ^(cur & fb_mask);

  assign chip = ({1'b0, sel} < len) ? cur[sel] : 1'b0;
  assign adv  = {cur[gcg_pkg::REG_W-2:0], fb} & mask;

endmodule

// ===== rtl/gcg_checker.sv =====
// ----------------------------------------------------------------------------
// gcg_checker
// Port-level checks for the gold code generator, bound to the top level.
// ----------------------------------------------------------------------------
module gcg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           restart,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           code_bit,
  input logic [15:0]                    chip_index,
  input logic                           period_end
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chip_index)
      && $stable(code_bit) && $stable(period_end))
    else $error("output changed while stalled");

  // no new input while the result register is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // restart transfer yields chip zero next cycle
  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && restart |=> out_valid && chip_index == 16'd0
      && !period_end)
    else $error("restart did not start a new period");

  // last chip index of a period is 2^L-2: even and nonzero
  a_end_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && period_end |-> chip_index != 16'd0 && !chip_index[0])
    else $error("period end on an impossible chip index");

endmodule

bind gold_code_generator gcg_checker u_gcg_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gold code generator. A local predictor tracks
// both shift registers, the chip counter and the seven settings, and works
// out each chip as its input transfer is accepted. Results are checked in
// order against that prediction. Stimulus runs directed corner cases, a
// backpressure burst, one full period with no idling and random phases
// with fresh settings, the rest under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          IDLE_PCT     = 26;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          RANDOM_CHIPS = 1000;
  localparam int          LIMIT_CYCLES = 1000000;
  // the only index with no register behind it
  localparam logic [2:0]  CFG_UNUSED   = 3'd7;

  typedef struct packed {
    logic        code_bit;
    logic [15:0] chip_index;
    logic        period_end;
  } chip_t;

  // dut ports
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        restart    = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        code_bit;
  logic [15:0] chip_index;
  logic        period_end;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [gcg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gcg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state: settings, both registers and the chip counter
  gcg_pkg::cfg_t  gen_cfg;
  gcg_pkg::lfsr_t reg_a;
  gcg_pkg::lfsr_t reg_b;
  int unsigned    chip_cnt;

  // restart flags waiting to be sent, chips predicted but not yet seen
  bit    chip_q[$];
  chip_t expected_chips[$];

  int chips_issued  = 0;
  int chips_checked = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  // idling knobs and the long sink hold-off request
  int src_idle_pct  = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  gold_code_generator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_bit   (code_bit),
    .chip_index (chip_index),
    .period_end (period_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // chip predictor
  // --------------------------------------------------------------------------

  // programmed length pulled into the supported range
  function automatic int unsigned used_len();
    int unsigned l;
    l = gen_cfg.seq_length;
    if (l < gcg_pkg::MIN_LENGTH) l = gcg_pkg::MIN_LENGTH;
    if (l > gcg_pkg::MAX_LENGTH) l = gcg_pkg::MAX_LENGTH;
    return l;
  endfunction

  function automatic gcg_pkg::lfsr_t stage_mask(int unsigned l);
    return gcg_pkg::lfsr_t'((32'd1 << l) - 1);
  endfunction

  // load both registers from the initial vectors, drop stages past the length
  function automatic void reload_gen();
    gcg_pkg::lfsr_t m;
    m        = stage_mask(used_len());
    reg_a    = gen_cfg.init_a & m;
    reg_b    = gen_cfg.init_b & m;
    chip_cnt = 0;
  endfunction

  // one shift: last stage always feeds back, taps at or above it are ignored
  function automatic gcg_pkg::lfsr_t next_state(gcg_pkg::lfsr_t r,
                                                gcg_pkg::lfsr_t taps,
                                                int unsigned l);
    logic fb;
    fb = r[l-1];
    for (int i = 0; i < int'(l) - 1; i++)
      if (taps[i]) fb ^= r[i];
    return ((r << 1) | gcg_pkg::lfsr_t'(fb)) & stage_mask(l);
  endfunction

  function automatic chip_t next_chip(bit reload_req);
    int unsigned l;
    logic        bit_a;
    logic        bit_b;
    chip_t       c;
    l = used_len();
    if (reload_req) reload_gen();
    // a select at or past the length reads 0
    bit_a        = (gen_cfg.select_a < l) ? reg_a[gen_cfg.select_a] : 1'b0;
    bit_b        = (gen_cfg.select_b < l) ? reg_b[gen_cfg.select_b] : 1'b0;
    c.code_bit   = bit_a ^ bit_b;
    c.chip_index = 16'(chip_cnt);
    c.period_end = (chip_cnt >= (32'd1 << l) - 2);
    if (c.period_end) begin
      reload_gen();
    end else begin
      reg_a    = next_state(reg_a, gen_cfg.taps_a, l);
      reg_b    = next_state(reg_b, gen_cfg.taps_b, l);
      chip_cnt = chip_cnt + 1;
    end
    return c;
  endfunction

  // register write: any real index reloads, the unused one changes nothing
  function automatic void apply_write(logic [2:0] idx, logic [15:0] data);
    case (idx)
      gcg_pkg::CFG_SEQ_LENGTH: gen_cfg.seq_length = data[gcg_pkg::LEN_W-1:0];
      gcg_pkg::CFG_TAPS_A:     gen_cfg.taps_a     = data;
      gcg_pkg::CFG_TAPS_B:     gen_cfg.taps_b     = data;
      gcg_pkg::CFG_INIT_A:     gen_cfg.init_a     = data;
      gcg_pkg::CFG_INIT_B:     gen_cfg.init_b     = data;
      gcg_pkg::CFG_SELECT_A:   gen_cfg.select_a   = data[gcg_pkg::SEL_W-1:0];
      gcg_pkg::CFG_SELECT_B:   gen_cfg.select_b   = data[gcg_pkg::SEL_W-1:0];
      default:                 return;
    endcase
    reload_gen();
  endfunction

  // --------------------------------------------------------------------------
  // input driver: takes restart flags off chip_q, predicts on each transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      restart  <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_chips.push_back(next_chip(restart));
      // a held item stays on the bus until it is taken
      if (!in_valid || in_ready) begin
        if (chip_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          restart  <= chip_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output monitor: checks each transfer, drives random and long stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    chip_t got;
    chip_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chips_checked++;
        got = {code_bit, chip_index, period_end};
        if (expected_chips.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected chip bit=%0b index=%0d end=%0b",
                     $realtime, got.code_bit, got.chip_index, got.period_end);
        end else begin
          want = expected_chips.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: chip mismatch exp bit=%0b index=%0d end=%0b,",
                        " got bit=%0b index=%0d end=%0b"},
                       $realtime, want.code_bit, want.chip_index, want.period_end,
                       got.code_bit, got.chip_index, got.period_end);
          end
        end
      end
      // long hold-off, counted here, so the block backs up into its input
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_reqs) begin
        out_ready   <= 1'b0;
        hold_left   <= HOLD_CYCLES;
        hold_served <= hold_served + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_chip(bit r);
    chip_q.push_back(r);
    chips_issued++;
  endfunction

  // wait until every queued chip has come back, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk); while (chips_checked < chips_issued);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_write(idx, data);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          random_done;
    int          n;
    int          restart_pct;
    int          pick;
    logic [2:0]  idx;
    logic [15:0] data;

    gen_cfg.seq_length = gcg_pkg::RST_SEQ_LENGTH;
    gen_cfg.taps_a     = gcg_pkg::RST_TAPS;
    gen_cfg.taps_b     = gcg_pkg::RST_TAPS;
    gen_cfg.init_a     = gcg_pkg::RST_INIT;
    gen_cfg.init_b     = gcg_pkg::RST_INIT;
    gen_cfg.select_a   = gcg_pkg::RST_SELECT;
    gen_cfg.select_b   = gcg_pkg::RST_SELECT;
    reload_gen();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults out of reset, restart in the middle of the sequence
    queue_chip(1'b0);
    queue_chip(1'b0);
    queue_chip(1'b1);
    queue_chip(1'b0);

    // length 0 pulls up to 2, init bits above the length dropped,
    // every tap set including the last stage, select A past the length
    cfg_write(gcg_pkg::CFG_SEQ_LENGTH, 16'd0);
    cfg_write(gcg_pkg::CFG_TAPS_A, 16'hFFFF);
    cfg_write(gcg_pkg::CFG_INIT_A, 16'hFFFF);
    cfg_write(gcg_pkg::CFG_TAPS_B, 16'h0000);
    cfg_write(gcg_pkg::CFG_INIT_B, 16'h0002);
    cfg_write(gcg_pkg::CFG_SELECT_A, 16'd15);
    cfg_write(gcg_pkg::CFG_SELECT_B, 16'd1);
    repeat (4) queue_chip(1'b0);

    // length 1 also pulls up to 2
    cfg_write(gcg_pkg::CFG_SEQ_LENGTH, 16'd1);
    cfg_write(gcg_pkg::CFG_SELECT_A, 16'd0);
    repeat (3) queue_chip(1'b0);

    // oversize length pulls down to 16, register A stuck at zero
    cfg_write(gcg_pkg::CFG_SEQ_LENGTH, 16'd31);
    cfg_write(gcg_pkg::CFG_INIT_A, 16'h0000);
    cfg_write(gcg_pkg::CFG_INIT_B, 16'hFFFF);
    cfg_write(gcg_pkg::CFG_SELECT_B, 16'd15);
    repeat (3) queue_chip(1'b0);

    // write to the unused index: no reload, sequence carries on
    cfg_write(CFG_UNUSED, 16'hFFFF);
    queue_chip(1'b0);
    queue_chip(1'b0);
    queue_chip(1'b1);

    cfg_write(gcg_pkg::CFG_SEQ_LENGTH, 16'd17);
    repeat (2) queue_chip(1'b0);
    cfg_write(gcg_pkg::CFG_SEQ_LENGTH, 16'hFFE2);
    repeat (3) queue_chip(1'b0);

    // sink holds off while the source keeps offering, input must stall
    cfg_write(gcg_pkg::CFG_SEQ_LENGTH, 16'd5);
    cfg_write(gcg_pkg::CFG_TAPS_A, 16'h0004);
    cfg_write(gcg_pkg::CFG_INIT_A, 16'h0001);
    hold_reqs <= hold_reqs + 1;
    repeat (40) queue_chip($urandom_range(99) < 5);

    // one whole period at length 8 with no idling anywhere,
    // so the counter reaches its top value and wraps
    cfg_write(gcg_pkg::CFG_TAPS_B, 16'h6801);
    cfg_write(gcg_pkg::CFG_SEQ_LENGTH, 16'd8);
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    repeat (256) queue_chip(1'b0);
    wait_idle();
    src_idle_pct  <= IDLE_PCT;
    sink_idle_pct <= IDLE_PCT;

    // random phases: fresh settings, then a run of mostly clean chips;
    // short lengths dominate so periods complete often
    random_done = 0;
    while (random_done < RANDOM_CHIPS) begin
      repeat ($urandom_range(1, 3)) begin
        idx = 3'($urandom_range(0, 7));
        case (idx)
          gcg_pkg::CFG_SEQ_LENGTH: begin
            pick = $urandom_range(99);
            if (pick < 75)      data = {11'($urandom), 5'($urandom_range(2, 7))};
            else if (pick < 90) data = {11'($urandom), 5'($urandom_range(8, 16))};
            else                data = 16'($urandom);
          end
          gcg_pkg::CFG_INIT_A, gcg_pkg::CFG_INIT_B:
            data = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
          default:
            data = 16'($urandom);
        endcase
        cfg_write(idx, data);
      end
      // now and then a phase full of restarts
      restart_pct = ($urandom_range(9) == 0) ? 30 : 2;
      n = $urandom_range(40, 90);
      repeat (n) queue_chip($urandom_range(99) < restart_pct);
      random_done += n;
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_chips.size() != 0) begin
      mismatches++;
      $display("%0d chips never came out", expected_chips.size());
    end
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== gold_code_generator.f =====
rtl/gcg_pkg.sv
rtl/gcg_cfg.sv
rtl/gcg_lfsr.sv
rtl/gold_code_generator.sv
rtl/gcg_checker.sv
tb/tb_top.sv
